// ===== hdl/assert_macros.svh =====
// Assertion macros for the histogram RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold on a clock edge outside reset
`define CHK_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// ante on a clock edge implies cons on the same edge
`define CHK_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/phu_pkg.sv =====
// Types and constants of the pixel histogram unit.
package phu_pkg;

  localparam int PIX_W     = 16;
  localparam int IDX_W     = 12;
  localparam int CNT_OUT_W = 32;

  localparam int DEF_NUM_BINS   = 4096;
  localparam int DEF_PIXEL_BITS = 16;
  localparam int DEF_COUNT_BITS = 32;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // register index, taken from paddr[CFG_AW-1]
  localparam logic CFG_REG_MIN_VALUE = 1'b0;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_COUNT = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } phu_op_t;

  typedef enum logic {
    ST_RUN,
    ST_CLEAR
  } phu_state_t;

  typedef struct packed {
    phu_op_t            opcode;
    logic [PIX_W-1:0]   pixel_value;
    logic [IDX_W-1:0]   bin_index;
  } phu_in_t;

  typedef struct packed {
    logic [CNT_OUT_W-1:0] bin_count;
    logic [CNT_OUT_W-1:0] dropped_count;
  } phu_out_t;

endpackage

// ===== hdl/phu_cfg_regs.sv =====
// APB register block holding the histogram base value.
module phu_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [phu_pkg::CFG_AW-1:0] paddr,
  input  logic [phu_pkg::CFG_DW-1:0] pwdata,
  output logic [phu_pkg::CFG_DW-1:0] prdata,
  output logic                      pready,
  output logic [phu_pkg::PIX_W-1:0]  min_value
);
  import phu_pkg::*;

  logic [PIX_W-1:0] min_value_r;
  logic             wr_en;
  logic             reg_idx;

  assign reg_idx = paddr[CFG_AW-1];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_value_r <= '0;
    end else if (wr_en && (reg_idx == CFG_REG_MIN_VALUE)) begin
      min_value_r <= pwdata[PIX_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == CFG_REG_MIN_VALUE) begin
      prdata = CFG_DW'(min_value_r);
    end
  end

  assign min_value = min_value_r;

endmodule

// ===== hdl/pixel_histogram_unit.sv =====
// Top level of the pixel histogram unit: bin store, read-modify-write pipe, clear sweep.
//
// Usage
//   Commands enter on in_data and transfer at a rising edge where start is high
//   and busy is low. Opcodes: clear all bins, count a pixel, read a bin.
//   A count subtracts min_value from the pixel; offsets below zero or at or
//   above NUM_BINS bump the saturating dropped counter instead of a bin.
//   A read returns bin_count and dropped_count on out_data, flagged by
//   out_valid for exactly one cycle, after stage 1 and the result register.
//   Count and read commands go one per cycle while busy is low: the bin RAM
//   is read in the transfer cycle and written back in the next cycle; a hit on
//   the bin being written is forwarded from a holding register, so repeated bins count right.
//   Clear holds busy while the sweep writes one zero per cycle through the RAM
//   write port until every bin is zero; it also zeroes the dropped counter.
//   After reset the same sweep runs, holding busy high, before the first
//   command is taken; APB writes to min_value are taken at any time.
//   The receiver cannot stall: results are not held, so none is ever delayed.
//   Write min_value only while no command is in flight.
`include "assert_macros.svh"

module pixel_histogram_unit #(
  parameter int NUM_BINS   = phu_pkg::DEF_NUM_BINS,
  parameter int PIXEL_BITS = phu_pkg::DEF_PIXEL_BITS,
  parameter int COUNT_BITS = phu_pkg::DEF_COUNT_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // command channel
  input  logic                       start,
  output logic                       busy,
  input  phu_pkg::phu_in_t           in_data,
  // result channel
  output logic                       out_valid,
  output phu_pkg::phu_out_t          out_data,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [phu_pkg::CFG_AW-1:0] paddr,
  input  logic [phu_pkg::CFG_DW-1:0] pwdata,
  output logic [phu_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import phu_pkg::*;

  localparam int ADDR_W = $clog2(NUM_BINS);
  // only the low PIXEL_BITS of the 16-bit pixel field take part (all 16 if PIXEL_BITS is larger)
  localparam int PW     = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;

  logic [PIX_W-1:0] min_value;

  phu_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .min_value (min_value)
  );

  // ---------------------------------------------------------------
  // control state: run or clear sweep
  // ---------------------------------------------------------------
  phu_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_ptr_r, clr_ptr_nxt;
  logic              clearing;
  logic              accept;
  logic              clr_last;

  assign accept   = start && !busy;
  assign clr_last = (clr_ptr_r == ADDR_W'(NUM_BINS - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RUN: begin
        if (accept && (in_data.opcode == OP_CLEAR)) state_nxt = ST_CLEAR;
      end
      ST_CLEAR: begin
        if (clr_last) state_nxt = ST_RUN;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    busy     = 1'b0;
    clearing = 1'b0;
    unique case (state_r)
      ST_RUN:   busy = 1'b0;
      ST_CLEAR: begin
        busy     = 1'b1;
        clearing = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  assign clr_ptr_nxt = clearing ? (clr_ptr_r + ADDR_W'(1)) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_ptr_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_ptr_r <= clr_ptr_nxt;
    end
  end

  // ---------------------------------------------------------------
  // stage 0: bin offset, range check, RAM read
  // ---------------------------------------------------------------
  logic [PW-1:0]     pix, base;
  logic [PW:0]       diff;
  logic [31:0]       off_w, idx_w;
  logic              pix_ok, idx_ok;
  logic [ADDR_W-1:0] rd_addr;
  logic              is_read, is_count;

  always_comb begin
    pix      = in_data.pixel_value[PW-1:0];
    base     = min_value[PW-1:0];
    diff     = {1'b0, pix} - {1'b0, base};
    off_w    = 32'(diff[PW-1:0]);
    idx_w    = 32'(in_data.bin_index);
    pix_ok   = !diff[PW] && (off_w < 32'(NUM_BINS));
    idx_ok   = idx_w < 32'(NUM_BINS);
    is_read  = (in_data.opcode == OP_READ);
    is_count = (in_data.opcode == OP_COUNT);
    rd_addr  = is_read ? idx_w[ADDR_W-1:0] : off_w[ADDR_W-1:0];
  end

  // ---------------------------------------------------------------
  // bin RAM: one write port, one registered read port
  // ---------------------------------------------------------------
  logic [COUNT_BITS-1:0] bin_mem [NUM_BINS];
  logic [COUNT_BITS-1:0] rdata_r;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bin_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= bin_mem[rd_addr];
  end

  // ---------------------------------------------------------------
  // stage 1: modify and write back, or build the read result
  // ---------------------------------------------------------------
  logic                  s1_valid_r, s1_valid_nxt;
  logic                  s1_read_r;
  logic                  s1_hit_r;
  logic [ADDR_W-1:0]     s1_addr_r;
  logic                  fwd_hit_r, fwd_hit_nxt;
  logic [COUNT_BITS-1:0] fwd_data_r;
  logic [COUNT_BITS-1:0] cur, bin_inc;
  logic                  s1_we, s1_drop;
  logic [COUNT_BITS-1:0] dropped_r, dropped_nxt;

  assign s1_valid_nxt = accept && (is_read || is_count);

  // transfer on the bin being written right now: RAM would return the old value
  assign fwd_hit_nxt  = s1_we && s1_valid_nxt && (rd_addr == s1_addr_r);

  assign cur     = fwd_hit_r ? fwd_data_r : rdata_r;
  assign bin_inc = (&cur) ? cur : (cur + COUNT_BITS'(1));
  assign s1_we   = s1_valid_r && !s1_read_r && s1_hit_r;
  assign s1_drop = s1_valid_r && !s1_read_r && !s1_hit_r;

  always_comb begin
    mem_we    = s1_we;
    mem_waddr = s1_addr_r;
    mem_wdata = bin_inc;
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clr_ptr_r;
      mem_wdata = '0;
    end
  end

  always_comb begin
    dropped_nxt = dropped_r;
    if (clearing) begin
      dropped_nxt = '0;
    end else if (s1_drop && !(&dropped_r)) begin
      dropped_nxt = dropped_r + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
      dropped_r  <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      fwd_hit_r  <= fwd_hit_nxt;
      dropped_r  <= dropped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_read_r  <= is_read;
    s1_hit_r   <= is_read ? idx_ok : pix_ok;
    s1_addr_r  <= rd_addr;
    fwd_data_r <= bin_inc;
  end

  // ---------------------------------------------------------------
  // result register: one-cycle strobe
  // ---------------------------------------------------------------
  logic     out_valid_r, out_valid_nxt;
  phu_out_t out_data_r, out_data_nxt;

  always_comb begin
    out_valid_nxt              = s1_valid_r && s1_read_r;
    out_data_nxt.bin_count     = s1_hit_r ? CNT_OUT_W'(cur) : '0;
    out_data_nxt.dropped_count = CNT_OUT_W'(dropped_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------
  `CHK_NEVER(a_no_stage_in_clear, clearing && s1_valid_r, "stage 1 busy during clear sweep")
  `CHK_IMPLIES(a_fwd_live, fwd_hit_r, s1_valid_r, "forward flag without stage 1 item")
  `CHK_IMPLIES(a_out_from_read, out_valid_r, $past(accept && is_read, 2), "result without read")
  `CHK_IMPLIES(a_clear_no_result, clearing, !out_valid_nxt, "result produced during sweep")

endmodule
